@@ rtl/aas_pkg.sv @@
// Shared types and constants for the averaged ADC airspeed square-root core.
package aas_pkg;

    localparam int ADC_W       = 10;
    localparam int OUT_W       = 18;
    localparam int WORD_W      = 64;
    localparam int STEP_W      = 6;
    localparam int ROOT_W      = 17;

    localparam int AVG_COUNT_DEF = 20;
    localparam int DEADBAND_DEF  = 2;
    localparam int ADC_MID       = 512;
    localparam int ADC_FULL      = 1023;

    // 16384 * 82021^2 and 301 * 125 * 1023.
    localparam logic [WORD_W-1:0] SPEED_NUM = 64'd110222449721344;
    localparam longint unsigned   SPEED_DEN = 64'd38490375;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_SETUP,
        ST_MUL,
        ST_TRY,
        ST_ADJ,
        ST_OUT
    } t_state;

endpackage

@@ rtl/aas_if.sv @@
// Valid/ready channel interfaces for samples, speed results and the offset register.
interface aas_sample_if;
    import aas_pkg::*;
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;
    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface aas_speed_if;
    import aas_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] airspeed;
    modport source (output valid, output airspeed, input ready);
    modport sink (input valid, input airspeed, output ready);
endinterface

interface aas_cfg_if;
    import aas_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ADC_W-1:0] zero_offset;
    modport source (output valid, output zero_offset, input ready);
    modport sink (input valid, input zero_offset, output ready);
endinterface

@@ rtl/aas_alu.sv @@
// Shared adder/subtractor used by the multiply and square-root steps.
module aas_alu #(
    parameter int W = aas_pkg::WORD_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_carry
);
    logic [W-1:0] b_in;

    // On subtract, a set carry means i_a >= i_b.
    assign b_in = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_in} + {{W{1'b0}}, i_sub};
endmodule

@@ rtl/aas_accum.sv @@
// Offset-corrected sample accumulator that hands off one block sum per block.
module aas_accum #(
    parameter int AVERAGE_COUNT = aas_pkg::AVG_COUNT_DEF,
    parameter int SUM_W         = 12,
    parameter int CNT_W         = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [aas_pkg::ADC_W-1:0]       i_sample,
    input  logic signed [aas_pkg::ADC_W-1:0] i_offset,
    output logic                            o_last,
    output logic signed [SUM_W-1:0]         o_blk_sum
);
    import aas_pkg::*;

    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   n_sum;
    logic [CNT_W-1:0]          r_count;
    logic signed [ADC_W+1:0]   term;
    logic signed [SUM_W-1:0]   r_blk;

    assign term   = $signed({2'b00, i_sample}) - $signed({{2{i_offset[ADC_W-1]}}, i_offset});
    assign n_sum  = r_sum + SUM_W'(term);
    assign o_last = (r_count == CNT_W'(AVERAGE_COUNT - 1));
    assign o_blk_sum = r_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            if (o_last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && o_last) begin
            r_blk <= n_sum;
        end
    end
endmodule

@@ rtl/averaged_adc_airspeed_sqrt_core.sv @@
// Samples are taken one per cycle while a block of AVERAGE_COUNT fills.
// After the last sample of a block the sample port is not ready while the core sets up,
// multiplies and takes the square root, one shared 64-bit adder step per cycle, and the
// result is valid when the port is ready again; inside the deadband both steps are skipped.
// A held result stalls the core only once the next block's result is ready.
// Synchronous active-low reset clears the running sum, offset, sequencer and result valid.
module averaged_adc_airspeed_sqrt_core #(
    parameter int AVERAGE_COUNT = aas_pkg::AVG_COUNT_DEF,
    parameter int DEADBAND_HALF = aas_pkg::DEADBAND_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aas_sample_if.sink  i_sample,
    aas_cfg_if.sink     i_cfg,
    aas_speed_if.source o_speed
);
    import aas_pkg::*;

    localparam int CNT_W = (AVERAGE_COUNT > 1) ? $clog2(AVERAGE_COUNT) : 1;
    localparam int SUM_W = $clog2(1536 * AVERAGE_COUNT) + 1;
    localparam int D_W   = $clog2(2048 * AVERAGE_COUNT);
    localparam int CMP_W = SUM_W + 2;
    localparam longint unsigned DEN_VAL = SPEED_DEN * longint'(AVERAGE_COUNT);
    localparam int TOP_SH = 2 * (ROOT_W - 1);

    localparam logic signed [CMP_W-1:0] LO_C   =
        CMP_W'((ADC_MID - DEADBAND_HALF) * AVERAGE_COUNT);
    localparam logic signed [CMP_W-1:0] HI_C   =
        CMP_W'((ADC_MID + DEADBAND_HALF) * AVERAGE_COUNT);
    localparam logic signed [CMP_W-1:0] MID_C  = CMP_W'(ADC_MID * AVERAGE_COUNT);
    localparam logic signed [CMP_W-1:0] FULL_C = CMP_W'(ADC_FULL * AVERAGE_COUNT);
    localparam logic [WORD_W-1:0]       DEN_C  = WORD_W'(DEN_VAL);
    localparam logic [WORD_W-1:0]       T_INIT  = DEN_C << TOP_SH;
    localparam logic [WORD_W-1:0]       KQ_INIT = DEN_C << (TOP_SH - 2);
    localparam logic [WORD_W-1:0]       K3_INIT = (DEN_C + (DEN_C << 1)) << (TOP_SH - 2);

    t_state r_state, n_state;

    logic                    in_fire;
    logic                    acc_last;
    logic signed [SUM_W-1:0] blk_sum;
    logic signed [ADC_W-1:0] r_offset;

    logic [STEP_W-1:0]  r_step;
    logic [WORD_W-1:0]  r_p;
    logic [WORD_W-1:0]  r_t;
    logic [WORD_W-1:0]  r_kq;
    logic [WORD_W-1:0]  r_k3;
    logic [D_W-1:0]     r_d;
    logic               r_neg;
    logic [ROOT_W-1:0]  r_root;

    logic                    r_ovalid;
    logic signed [OUT_W-1:0] r_odata;

    logic signed [CMP_W-1:0] s_ext;
    logic signed [CMP_W-1:0] diff;
    logic [CMP_W-1:0]        d_abs;
    logic                    dead;
    logic [OUT_W-1:0]        mag;
    logic                    out_load;

    logic [WORD_W-1:0] alu_a, alu_b, alu_sum;
    logic              alu_sub, alu_carry;

    assign in_fire        = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == ST_ACC);
    assign i_cfg.ready    = 1'b1;
    assign o_speed.valid    = r_ovalid;
    assign o_speed.airspeed = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_offset <= i_cfg.zero_offset;
        end
    end

    aas_accum #(
        .AVERAGE_COUNT(AVERAGE_COUNT),
        .SUM_W        (SUM_W),
        .CNT_W        (CNT_W)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_sample (i_sample.adc_sample),
        .i_offset (r_offset),
        .o_last   (acc_last),
        .o_blk_sum(blk_sum)
    );

    aas_alu #(.W(WORD_W)) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_sum  (alu_sum),
        .o_carry(alu_carry)
    );

    // Block classification from the finished sum.
    assign s_ext = CMP_W'(blk_sum);
    assign diff  = (s_ext <<< 1) - FULL_C;
    assign d_abs = diff[CMP_W-1] ? CMP_W'(-diff) : CMP_W'(diff);
    assign dead  = (s_ext > LO_C) && (s_ext < HI_C);

    assign mag      = OUT_W'(r_root);
    assign out_load = (r_state == ST_OUT) && (!r_ovalid || o_speed.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            ST_ACC: begin
                if (in_fire && acc_last) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = dead ? ST_OUT : ST_MUL;
            end
            ST_MUL: begin
                // Shift-and-add, most significant bit of d first, modulo 2^64.
                alu_a = r_p << 1;
                alu_b = r_d[D_W-1] ? SPEED_NUM : '0;
                if (r_step == '0) begin
                    n_state = ST_TRY;
                end
            end
            ST_TRY: begin
                alu_a   = r_p;
                alu_b   = r_t;
                alu_sub = 1'b1;
                n_state = (r_step == '0) ? ST_OUT : ST_ADJ;
            end
            ST_ADJ: begin
                alu_a   = r_t >> 1;
                alu_b   = r_root[0] ? r_k3 : r_kq;
                alu_sub = !r_root[0];
                n_state = ST_TRY;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    // The root r is built one bit at a time as the largest value with
    // r*r*DEN <= product. r_p holds product - r*r*DEN, and r_t holds the
    // increase of r*r*DEN that setting the current bit would cause.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SETUP: begin
                r_d    <= d_abs[D_W-1:0];
                r_neg  <= (s_ext < MID_C);
                r_p    <= '0;
                r_t    <= T_INIT;
                r_kq   <= KQ_INIT;
                r_k3   <= K3_INIT;
                r_root <= '0;
                r_step <= STEP_W'(D_W - 1);
            end
            ST_MUL: begin
                r_p    <= alu_sum;
                r_d    <= r_d << 1;
                r_step <= (r_step == '0) ? STEP_W'(ROOT_W - 1) : r_step - 1'b1;
            end
            ST_TRY: begin
                r_p    <= alu_carry ? alu_sum : r_p;
                r_root <= {r_root[ROOT_W-2:0], alu_carry};
            end
            ST_ADJ: begin
                // Move the trial increment down one bit position.
                r_t    <= alu_sum;
                r_kq   <= r_kq >> 2;
                r_k3   <= r_k3 >> 2;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_speed.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= r_neg ? $signed(-mag) : $signed(mag);
        end
    end
endmodule

@@ rtl/aas_checker.sv @@
// Port-level checks for the airspeed core, bound to the top level.
module aas_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            cfg_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic signed [aas_pkg::OUT_W-1:0] out_airspeed
);
    logic in_fire;

    assign in_fire = in_valid && in_ready;

    // A waiting result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_airspeed))
        else $error("result changed or dropped while stalled");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_ready)
        else $error("offset register port not ready");

    // The core only goes busy right after taking the last sample of a block.
    a_busy_after_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(in_ready) |-> $past(in_fire))
        else $error("sample port went busy without a sample");

    // A result never appears in the cycle right after an accepted sample.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> !$past(in_fire))
        else $error("result appeared too early");

    // Leaving the busy phase always leaves a result behind.
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("sample port ready again without a result");
endmodule

bind averaged_adc_airspeed_sqrt_core aas_checker u_aas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_sample.valid),
    .in_ready    (i_sample.ready),
    .cfg_ready   (i_cfg.ready),
    .out_valid   (o_speed.valid),
    .out_ready   (o_speed.ready),
    .out_airspeed(o_speed.airspeed)
);
